// ===== src/lzsstd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzsstd_pkg
// Shared types and constants for the LZSS token decompressor.
// ----------------------------------------------------------------------------
package lzsstd_pkg;

    localparam int WIN_DEPTH   = 4096;
    localparam int WIN_AW      = 12;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 32;
    localparam int LEN_W       = 5;
    localparam int MIN_MATCH   = 3;
    localparam int MAX_RESULTS = 18;

    localparam logic        MODE_LITERAL = 1'b0;
    localparam logic        MODE_MATCH   = 1'b1;

    localparam logic [1:0]  STATUS_OK    = 2'd0;
    localparam logic [1:0]  STATUS_FAR   = 2'd1;
    localparam logic [1:0]  STATUS_DONE  = 2'd2;

    typedef struct packed {
        logic              first_token;
        logic              mode;
        logic [BYTE_W-1:0] literal_byte;
        logic [11:0]       offset_code;
        logic [3:0]        length_code;
    } token_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic [1:0]        status;
        logic              last;
        logic              finished;
    } result_t;

    typedef struct packed {
        logic              wr_en;
        logic [WIN_AW-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [WIN_AW-1:0] rd_addr;
    } mem_req_t;

endpackage : lzsstd_pkg
`default_nettype wire

// ===== src/lzsstd_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzsstd_window
// History window: single-port-write, single-port-read synchronous RAM with
// registered read data and same-address write forwarding.
// ----------------------------------------------------------------------------
module lzsstd_window
    import lzsstd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mem_req_t          req,
    output logic [BYTE_W-1:0]      rd_data
);

    logic [BYTE_W-1:0] ram_mem [WIN_DEPTH];
    logic [BYTE_W-1:0] q_reg;
    logic [BYTE_W-1:0] fwd_byte_reg;
    logic              fwd_reg;
    logic              fwd_next;

    assign fwd_next = req.wr_en && (req.wr_addr == req.rd_addr);

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            ram_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            q_reg        <= ram_mem[req.rd_addr];
            fwd_byte_reg <= req.wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (req.rd_en)
        begin
            fwd_reg <= fwd_next;
        end
    end

    assign rd_data = fwd_reg ? fwd_byte_reg : q_reg;

endmodule : lzsstd_window
`default_nettype wire

// ===== src/lzsstd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzsstd_ctrl
// Token sequencer: holds the produced count and write pointer, classifies
// each token and drives the window for literals and match copies.
// ----------------------------------------------------------------------------
module lzsstd_ctrl
    import lzsstd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              tok_valid,
    output logic                   tok_ready,
    input  wire token_t            tok,
    input  wire logic [CNT_W-1:0]  total_length,
    input  wire logic              slot_free,
    output logic                   push,
    output result_t                res,
    output mem_req_t               mem_req,
    input  wire logic [BYTE_W-1:0] rd_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_COPY
    } state_t;

    state_t            state_reg, state_next;
    token_t            tok_reg, tok_next;
    logic [CNT_W-1:0]  prod_reg, prod_next;
    logic [WIN_AW-1:0] wp_reg, wp_next;
    logic [WIN_AW-1:0] src_reg, src_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;

    logic [CNT_W-1:0]  prod_inc;
    logic [CNT_W-1:0]  rem;
    logic [LEN_W-1:0]  len_full;
    logic [LEN_W-1:0]  len_cap;
    logic [LEN_W-1:0]  len_eff;
    logic [12:0]       match_dist;
    logic              dist_far;
    logic              at_total;
    logic [WIN_AW-1:0] src_first;

    assign prod_inc   = prod_reg + CNT_W'(1);
    assign rem        = total_length - prod_reg;
    assign len_full   = LEN_W'(tok_reg.length_code) + LEN_W'(MIN_MATCH);
    assign len_cap    = (len_full > LEN_W'(MAX_RESULTS)) ? LEN_W'(MAX_RESULTS) : len_full;
    assign len_eff    = (rem < CNT_W'(len_cap)) ? rem[LEN_W-1:0] : len_cap;
    assign match_dist = {1'b0, tok_reg.offset_code} + 13'd1;
    assign dist_far   = CNT_W'(match_dist) > prod_reg;
    assign at_total   = prod_reg >= total_length;
    assign src_first  = wp_reg + ~tok_reg.offset_code;

    assign tok_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        tok_next   = tok_reg;
        prod_next  = prod_reg;
        wp_next    = wp_reg;
        src_next   = src_reg;
        cnt_next   = cnt_reg;
        push       = 1'b0;
        res        = '0;
        mem_req    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tok_valid)
                begin
                    tok_next   = tok;
                    state_next = ST_DECIDE;
                    if (tok.first_token)
                    begin
                        prod_next = '0;
                        wp_next   = '0;
                    end
                end
            end

            ST_DECIDE:
            begin
                if (slot_free)
                begin
                    priority if (at_total)
                    begin
                        push         = 1'b1;
                        res.status   = STATUS_DONE;
                        res.last     = 1'b1;
                        res.finished = (prod_reg == total_length);
                        state_next   = ST_IDLE;
                    end
                    else if (tok_reg.mode == MODE_LITERAL)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = wp_reg;
                        mem_req.wr_data = tok_reg.literal_byte;
                        wp_next         = wp_reg + WIN_AW'(1);
                        prod_next       = prod_inc;
                        push            = 1'b1;
                        res.out_byte    = tok_reg.literal_byte;
                        res.byte_valid  = 1'b1;
                        res.status      = STATUS_OK;
                        res.last        = 1'b1;
                        res.finished    = (prod_inc == total_length);
                        state_next      = ST_IDLE;
                    end
                    else if (dist_far)
                    begin
                        push         = 1'b1;
                        res.status   = STATUS_FAR;
                        res.last     = 1'b1;
                        res.finished = (prod_reg == total_length);
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = src_first;
                        src_next        = src_first;
                        cnt_next        = len_eff;
                        state_next      = ST_COPY;
                    end
                end
            end

            ST_COPY:
            begin
                if (slot_free)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = wp_reg;
                    mem_req.wr_data = rd_data;
                    wp_next         = wp_reg + WIN_AW'(1);
                    prod_next       = prod_inc;
                    push            = 1'b1;
                    res.out_byte    = rd_data;
                    res.byte_valid  = 1'b1;
                    res.status      = STATUS_OK;
                    res.last        = (cnt_reg == LEN_W'(1));
                    res.finished    = (prod_inc == total_length);
                    cnt_next        = cnt_reg - LEN_W'(1);
                    if (cnt_reg == LEN_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = src_reg + WIN_AW'(1);
                        src_next        = src_reg + WIN_AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            prod_reg  <= '0;
            wp_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            prod_reg  <= prod_next;
            wp_reg    <= wp_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        src_reg <= src_next;
    end

endmodule : lzsstd_ctrl
`default_nettype wire

// ===== src/lzss_token_decompressor_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzss_token_decompressor_core
// LZSS decompressor for pre-split tokens with a 4 KiB history window.
// ----------------------------------------------------------------------------
// Tokens are taken one at a time. A literal, an out-of-range offset or a
// token arriving after the total length has been reached is accepted, then
// classified, emitting one result. A match is accepted and classified: the
// first window read is issued in the classify state and the window's single
// read port then delivers one byte per cycle while the output is free, with
// a byte being written forwarded to a same-cycle read of that entry so that
// overlapping copies repeat correctly. Results leave through an output
// register; back-pressure on the result side stalls the copy in place.
// total_length is written through cfg_wr_en/cfg_wr_data, only while idle by
// the user; the block does not enforce it. The window is not cleared at
// reset: only bytes of the current stream are ever read.
// ----------------------------------------------------------------------------
module lzss_token_decompressor_core
    import lzsstd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,  // total_length
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,      // literal_byte[7:0], offset_code[19:8],
                                           // length_code[23:20]
    input  wire logic [1:0]  s_tuser,      // first_token[0], mode[1]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,      // out_byte[7:0]
    output logic [3:0]       m_tuser,      // byte_valid[0], status[2:1], finished[3]
    output logic             m_tlast
);

    logic [CNT_W-1:0]  total_length_reg;
    logic              m_valid_reg;
    result_t           res_reg;
    token_t            tok;
    logic              slot_free;
    logic              push;
    result_t           res;
    mem_req_t          mem_req;
    logic [BYTE_W-1:0] rd_data;

    assign tok.first_token  = s_tuser[0];
    assign tok.mode         = s_tuser[1];
    assign tok.literal_byte = s_tdata[7:0];
    assign tok.offset_code  = s_tdata[19:8];
    assign tok.length_code  = s_tdata[23:20];

    assign slot_free = !m_valid_reg || m_tready;

    lzsstd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (s_tvalid),
        .tok_ready    (s_tready),
        .tok          (tok),
        .total_length (total_length_reg),
        .slot_free    (slot_free),
        .push         (push),
        .res          (res),
        .mem_req      (mem_req),
        .rd_data      (rd_data)
    );

    lzsstd_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_length_reg <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                total_length_reg <= cfg_wr_data;
            end
            if (push)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg.out_byte;
    assign m_tuser  = {res_reg.finished, res_reg.status, res_reg.byte_valid};
    assign m_tlast  = res_reg.last;

`ifndef SYNTHESIS
    a_push_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!m_valid_reg || m_tready))
        else $error("result pushed into an occupied output register");

    a_no_push_while_taking: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !push)
        else $error("result produced while a new token may be accepted");

    a_invalid_byte_has_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tuser[2:1] != STATUS_OK))
        else $error("result without a byte carries an ok status");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[2:1] != STATUS_OK)) |-> (m_tlast && m_tdata == 8'd0))
        else $error("error result is not the final, empty transaction");
`endif

endmodule : lzss_token_decompressor_core
`default_nettype wire
